// ----- design/mas_pkg.sv -----
package mas_pkg;

	// Fixed field widths of the result and element beats
	localparam int WORD_W = 32;
	localparam int IDX_W  = 2;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [IDX_W-1:0]  idx_t;

	// Result set carried on the kind field
	typedef enum logic [1:0] {
		KIND_SUM  = 2'd0,
		KIND_DIFF = 2'd1,
		KIND_PROD = 2'd2
	} kind_t;

	// Sequencer states of the core
	typedef enum logic [1:0] {
		ST_LOAD,
		ST_ISSUE,
		ST_WAIT
	} state_t;

endpackage

// ----- design/mas_ram.sv -----
module mas_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 9,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ----- design/matrix_add_sub_mul_core.sv -----
// Element beats: one per cycle while loading, 2*DIM*DIM per job (A then B),
// stalled otherwise. Results go one at a time through the single read port of each
// matrix RAM and the read / multiply / accumulate chain: one read per sum or
// difference beat, one per product term, the next issued once the last is loaded.
// Reset (arst_n low): load counter, sequencer and result valid clear at once;
// matrix RAM contents are left as they are.
module matrix_add_sub_mul_core #(
	parameter int DIM = 3
) (
	input  logic                clk,
	input  logic                arst_n,
	// element channel
	input  logic                elem_valid,
	output logic                elem_stall,
	input  logic signed [31:0]  element,
	// result channel
	output logic                res_valid,
	input  logic                res_stall,
	output logic [1:0]          kind,
	output logic [1:0]          row,
	output logic [1:0]          col,
	output logic signed [31:0]  value,
	output logic                last
);

	// Derived sizes: matrix entries, RAM address, load counter and row/col/term index
	localparam int CELLS = DIM * DIM;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(2 * CELLS);
	localparam int IW    = $clog2(DIM);

	localparam logic [IW-1:0] IDX_LAST  = IW'(DIM - 1);
	localparam logic [CW-1:0] CNT_SPLIT = CW'(CELLS);
	localparam logic [CW-1:0] CNT_LAST  = CW'(2 * CELLS - 1);

	// ---------------------------------------------------------------
	// Sequencer state
	// ---------------------------------------------------------------
	mas_pkg::state_t state_q, state_d;
	mas_pkg::kind_t  kind_q;
	logic [CW-1:0]   cnt_q;      // elements loaded in the current job
	logic [IW-1:0]   r_q, c_q;   // result element being computed
	logic [IW-1:0]   k_q;        // product term being issued

	logic elem_acc;      // element beat taken this cycle
	logic issue;         // RAM read issued this cycle
	logic issue_last;    // this read carries the final term of the result
	logic out_free;      // result register can take a new beat
	logic out_load;      // move finished accumulator into the result register
	logic res_end;       // current result is the final beat of the job

	// ---------------------------------------------------------------
	// Matrix RAMs: written during load, read during result sequencing
	// ---------------------------------------------------------------
	logic              a_we, b_we;
	logic [AW-1:0]     a_wr_addr, b_wr_addr;
	logic [AW-1:0]     a_rd_addr, b_rd_addr;
	mas_pkg::word_t    a_rd, b_rd;

	// Elements below CELLS fill A, the rest fill B
	assign a_we      = elem_acc && (cnt_q < CNT_SPLIT);
	assign b_we      = elem_acc && (cnt_q >= CNT_SPLIT);
	assign a_wr_addr = AW'(cnt_q);
	assign b_wr_addr = AW'(cnt_q - CNT_SPLIT);

	// Element-wise sets read A[r][c] and B[r][c]; the product reads A[r][k] and B[k][c]
	always_comb begin
		if (kind_q == mas_pkg::KIND_PROD) begin
			a_rd_addr = AW'(int'(r_q) * DIM + int'(k_q));
			b_rd_addr = AW'(int'(k_q) * DIM + int'(c_q));
		end else begin
			a_rd_addr = AW'(int'(r_q) * DIM + int'(c_q));
			b_rd_addr = AW'(int'(r_q) * DIM + int'(c_q));
		end
	end

	mas_ram #(
		.WIDTH(mas_pkg::WORD_W),
		.DEPTH(CELLS)
	) u_ram_a (
		.clk    (clk),
		.we     (a_we),
		.wr_addr(a_wr_addr),
		.wr_data(element),
		.rd_addr(a_rd_addr),
		.rd_data(a_rd)
	);

	mas_ram #(
		.WIDTH(mas_pkg::WORD_W),
		.DEPTH(CELLS)
	) u_ram_b (
		.clk    (clk),
		.we     (b_we),
		.wr_addr(b_wr_addr),
		.wr_data(element),
		.rd_addr(b_rd_addr),
		.rd_data(b_rd)
	);

	// ---------------------------------------------------------------
	// Next state
	// ---------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			mas_pkg::ST_LOAD: begin
				if (elem_acc && cnt_q == CNT_LAST) begin
					state_d = mas_pkg::ST_ISSUE;
				end
			end
			mas_pkg::ST_ISSUE: begin
				if (issue_last) begin
					state_d = mas_pkg::ST_WAIT;
				end
			end
			mas_pkg::ST_WAIT: begin
				if (out_load) begin
					state_d = res_end ? mas_pkg::ST_LOAD : mas_pkg::ST_ISSUE;
				end
			end
			default: state_d = mas_pkg::ST_LOAD;
		endcase
	end

	// ---------------------------------------------------------------
	// Sequencer outputs
	// ---------------------------------------------------------------
	logic acc_done_q;

	always_comb begin
		elem_stall = (state_q != mas_pkg::ST_LOAD);
		elem_acc   = elem_valid && (state_q == mas_pkg::ST_LOAD);
		issue      = (state_q == mas_pkg::ST_ISSUE);
		issue_last = issue && ((kind_q != mas_pkg::KIND_PROD) || (k_q == IDX_LAST));
		out_free   = !res_valid || !res_stall;
		out_load   = (state_q == mas_pkg::ST_WAIT) && acc_done_q && out_free;
		res_end    = (kind_q == mas_pkg::KIND_PROD) && (r_q == IDX_LAST) && (c_q == IDX_LAST);
	end

	// Control registers: state, load count, result coordinates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mas_pkg::ST_LOAD;
			cnt_q   <= '0;
			kind_q  <= mas_pkg::KIND_SUM;
			r_q     <= '0;
			c_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			// Count element beats; wrap to zero once B is complete
			if (elem_acc) begin
				cnt_q <= (cnt_q == CNT_LAST) ? '0 : cnt_q + 1'b1;
			end
			// Step through the product terms, restart for every result
			if (issue) begin
				k_q <= issue_last ? '0 : k_q + 1'b1;
			end
			// Advance column, then row, then result set
			if (out_load) begin
				if (c_q == IDX_LAST) begin
					c_q <= '0;
					if (r_q == IDX_LAST) begin
						r_q <= '0;
						case (kind_q)
							mas_pkg::KIND_SUM:  kind_q <= mas_pkg::KIND_DIFF;
							mas_pkg::KIND_DIFF: kind_q <= mas_pkg::KIND_PROD;
							default:            kind_q <= mas_pkg::KIND_SUM;
						endcase
					end else begin
						r_q <= r_q + 1'b1;
					end
				end else begin
					c_q <= c_q + 1'b1;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Datapath: RAM read -> term (add / sub / mul) -> accumulate
	// ---------------------------------------------------------------
	logic           rd_v_s1, rd_first_s1, rd_last_s1;
	logic           term_v_s2, term_first_s2, term_last_s2;
	mas_pkg::word_t term_s2;
	mas_pkg::word_t acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1    <= 1'b0;
			term_v_s2  <= 1'b0;
			acc_done_q <= 1'b0;
		end else begin
			rd_v_s1   <= issue;
			term_v_s2 <= rd_v_s1;
			// Flag the accumulator full after its last term; drop it once handed off
			if (term_v_s2 && term_last_s2) begin
				acc_done_q <= 1'b1;
			end else if (out_load) begin
				acc_done_q <= 1'b0;
			end
		end
	end

	// Term flags and values ride along with the valid bits
	always_ff @(posedge clk) begin
		rd_first_s1   <= (k_q == '0);
		rd_last_s1    <= issue_last;
		term_first_s2 <= rd_first_s1;
		term_last_s2  <= rd_last_s1;
		// Low 32 bits only: everything wraps modulo 2^32
		case (kind_q)
			mas_pkg::KIND_SUM:  term_s2 <= a_rd + b_rd;
			mas_pkg::KIND_DIFF: term_s2 <= a_rd - b_rd;
			default:            term_s2 <= mas_pkg::WORD_W'(a_rd * b_rd);
		endcase
		// First term seeds the accumulator, later ones add in
		if (term_v_s2) begin
			acc_q <= term_first_s2 ? term_s2 : acc_q + term_s2;
		end
	end

	// ---------------------------------------------------------------
	// Result register: holds a beat while the receiver stalls
	// ---------------------------------------------------------------
	logic           res_valid_q;
	mas_pkg::kind_t res_kind_q;
	mas_pkg::idx_t  res_row_q, res_col_q;
	mas_pkg::word_t res_value_q;
	logic           res_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_kind_q  <= kind_q;
			res_row_q   <= mas_pkg::idx_t'(r_q);
			res_col_q   <= mas_pkg::idx_t'(c_q);
			res_value_q <= acc_q;
			res_last_q  <= res_end;
		end
	end

	assign res_valid = res_valid_q;
	assign kind      = res_kind_q;
	assign row       = res_row_q;
	assign col       = res_col_q;
	assign value     = res_value_q;
	assign last      = res_last_q;

endmodule

// ----- bench/mas_result_checker.sv -----
module mas_result_checker #(
	parameter int DIM = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               elem_valid,
	input  logic               elem_stall,
	input  logic signed [31:0] element,
	input  logic               res_valid,
	input  logic               res_stall,
	input  logic [1:0]         kind,
	input  logic [1:0]         row,
	input  logic [1:0]         col,
	input  logic signed [31:0] value,
	input  logic               last,
	output int                 mismatches,
	output int                 pending
);

	localparam int CELLS = DIM * DIM;

	typedef struct packed {
		mas_pkg::kind_t kind;
		mas_pkg::idx_t  row;
		mas_pkg::idx_t  col;
		mas_pkg::word_t value;
		logic           last;
	} result_beat_t;

	mas_pkg::word_t mat_a [CELLS];
	mas_pkg::word_t mat_b [CELLS];
	int             loaded;
	result_beat_t   expected_beats [$];

	// Queue the sum, difference and product sets, each row-major, all mod 2^32.
	task automatic compute_job_results();
		result_beat_t   beat;
		mas_pkg::word_t acc;
		int             s, r, c, k;
		for (s = 0; s < 3; s++) begin
			for (r = 0; r < DIM; r++) begin
				for (c = 0; c < DIM; c++) begin
					beat.row  = mas_pkg::idx_t'(r);
					beat.col  = mas_pkg::idx_t'(c);
					beat.last = 1'b0;
					case (s)
						0: begin
							beat.kind  = mas_pkg::KIND_SUM;
							beat.value = mat_a[r*DIM+c] + mat_b[r*DIM+c];
						end
						1: begin
							beat.kind  = mas_pkg::KIND_DIFF;
							beat.value = mat_a[r*DIM+c] - mat_b[r*DIM+c];
						end
						default: begin
							acc = '0;
							for (k = 0; k < DIM; k++)
								acc = acc + mat_a[r*DIM+k] * mat_b[k*DIM+c];
							beat.kind  = mas_pkg::KIND_PROD;
							beat.value = acc;
							beat.last  = (r == DIM-1) && (c == DIM-1);
						end
					endcase
					expected_beats.push_back(beat);
				end
			end
		end
	endtask

	task automatic report_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		$display("%0t: result %s mismatch, expected %0h, got %0h", $time, field, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_beat_t want;
		logic         bad;
		if (!arst_n) begin
			loaded = 0;
			expected_beats.delete();
			mismatches <= 0;
			pending    <= 0;
		end else begin
			bad = 1'b0;
			// Retire results first: a beat at this edge never belongs to a job
			// that completes at this same edge.
			if (res_valid && !res_stall) begin
				if (expected_beats.size() == 0) begin
					$display("%0t: result beat with none expected,", $time,
						" got kind %0d row %0d col %0d value %0h",
						kind, row, col, value);
					bad = 1'b1;
				end else begin
					want = expected_beats.pop_front();
					if (kind !== want.kind) begin
						report_field("kind", 32'(want.kind), 32'(kind));
						bad = 1'b1;
					end
					if (row !== want.row) begin
						report_field("row", 32'(want.row), 32'(row));
						bad = 1'b1;
					end
					if (col !== want.col) begin
						report_field("col", 32'(want.col), 32'(col));
						bad = 1'b1;
					end
					if (value !== want.value) begin
						report_field("value", want.value, value);
						bad = 1'b1;
					end
					if (last !== want.last) begin
						report_field("last", 32'(want.last), 32'(last));
						bad = 1'b1;
					end
				end
				if (bad)
					mismatches <= mismatches + 1;
			end
			if (elem_valid && !elem_stall) begin
				if (loaded < CELLS)
					mat_a[loaded] = element;
				else
					mat_b[loaded-CELLS] = element;
				loaded++;
				if (loaded == 2*CELLS) begin
					loaded = 0;
					compute_job_results();
				end
			end
			pending <= expected_beats.size();
		end
	end

endmodule

// ----- bench/matrix_add_sub_mul_core_tb.sv -----
module matrix_add_sub_mul_core_tb;

	localparam int DIM          = 3;
	localparam int JOB_LEN      = 2 * DIM * DIM;
	// 25 random jobs plus a short partial job keeps the run near 470 beats
	localparam int RANDOM_JOBS  = 25;
	localparam int TAIL_BEATS   = 5;
	localparam int MAX_WAIT     = 16;
	// Worst job: 18 loads with full gaps plus 27 results each behind a full
	// stall and the product chain; the limit allows for it many times over.
	localparam int CYCLE_LIMIT  = 300000;
	// Wait well past the product read / accumulate chain for strays.
	localparam int DRAIN_CYCLES = 40;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               elem_valid;
	logic               elem_stall;
	logic signed [31:0] element;
	logic               res_valid;
	logic               res_stall;
	logic [1:0]         kind;
	logic [1:0]         row;
	logic [1:0]         col;
	logic signed [31:0] value;
	logic               last;

	int mismatches;
	int pending;
	int cycle_count   = 0;
	int sender_calm   = 0;
	int receiver_calm = 0;

	always #5 clk = ~clk;

	matrix_add_sub_mul_core #(
		.DIM(DIM)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.elem_valid(elem_valid),
		.elem_stall(elem_stall),
		.element   (element),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.kind      (kind),
		.row       (row),
		.col       (col),
		.value     (value),
		.last      (last)
	);

	// The checker owns prediction and comparison; this module only drives
	// beats and reports the verdict.
	mas_result_checker #(
		.DIM(DIM)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.elem_valid(elem_valid),
		.elem_stall(elem_stall),
		.element   (element),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.kind      (kind),
		.row       (row),
		.col       (col),
		.value     (value),
		.last      (last),
		.mismatches(mismatches),
		.pending   (pending)
	);

	// Draw an idle count for one beat. Now and then enter a calm stretch of
	// back-to-back beats so the block also sees full rate on that side.
	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0) begin
			calm = $urandom_range(10, 40);
			return 0;
		end
		return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, MAX_WAIT);
	endfunction

	// Element flavors: 0 full random, 1 small signed, 2 corner values,
	// anything else picks one of those per element.
	function automatic mas_pkg::word_t random_element(input int flavor);
		int pick;
		pick = (flavor > 2) ? $urandom_range(0, 2) : flavor;
		case (pick)
			1: return mas_pkg::word_t'($urandom_range(0, 16)) - 32'd8;
			2: begin
				case ($urandom_range(0, 5))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'hFFFF_FFFF;
					3: return 32'h0000_0000;
					4: return 32'h0000_0001;
					default: return 32'h8000_0001;
				endcase
			end
			default: return mas_pkg::word_t'($urandom);
		endcase
	endfunction

	// Present one element beat after a random gap and hold it until taken.
	// Leave valid high between back-to-back beats; never drop and raise it
	// in the same step.
	task automatic send_element(input mas_pkg::word_t elem);
		int gap;
		gap = draw_wait(sender_calm);
		if (gap > 0) begin
			elem_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		elem_valid <= 1'b1;
		element    <= elem;
		do @(posedge clk); while (elem_stall);
	endtask

	// Corner job: both extremes, all-ones and alternating bit patterns so the
	// sum, difference and product all wrap.
	mas_pkg::word_t corner_a [DIM*DIM] = '{
		32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
		32'h0000_0000, 32'h0000_0001, 32'h5555_5555,
		32'hAAAA_AAAA, 32'h7FFF_FFFF, 32'h8000_0000
	};
	mas_pkg::word_t corner_b [DIM*DIM] = '{
		32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
		32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hAAAA_AAAA,
		32'h5555_5555, 32'hFFFF_FFFF, 32'h8000_0000
	};

	// Element side: reset, corner job, random jobs, then a partial job that
	// must produce nothing.
	initial begin
		int job_flavor;
		elem_valid <= 1'b0;
		element    <= '0;
		arst_n     <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (corner_a[i])
			send_element(corner_a[i]);
		foreach (corner_b[i])
			send_element(corner_b[i]);

		for (int j = 0; j < RANDOM_JOBS; j++) begin
			job_flavor = $urandom_range(0, 3);
			for (int i = 0; i < JOB_LEN; i++)
				send_element(random_element(job_flavor));
		end

		for (int i = 0; i < TAIL_BEATS; i++)
			send_element(random_element(3));
		elem_valid <= 1'b0;

		// Let the checker count in the last accepted beat, then drain.
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Result side: before each beat, hold stall high for a random count,
	// then release it and wait for the beat to be taken.
	initial begin
		int hold;
		res_stall <= 1'b0;
		forever begin
			hold = draw_wait(receiver_calm);
			if (hold > 0) begin
				res_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				res_stall <= 1'b0;
			end
			do @(posedge clk); while (!res_valid);
		end
	end

	// Watchdog: a hang or a missing result ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

endmodule

// ----- files.f -----
design/mas_pkg.sv
design/mas_ram.sv
design/matrix_add_sub_mul_core.sv
bench/mas_result_checker.sv
bench/matrix_add_sub_mul_core_tb.sv
